// File: sv/v4n_pkg.sv
// Shared lane count and helper function for the four-component vector normaliser.
`default_nettype none

package v4n_pkg;

   // Number of vector components carried side by side through the chain.
   localparam int unsigned LANES = 4;

   function automatic int unsigned max_u(input int unsigned a, input int unsigned b);
      return (a > b) ? a : b;
   endfunction

endpackage

`default_nettype wire

// File: sv/v4n_if.sv
// Valid/ready channel interfaces for request and response beats.
`default_nettype none

interface v4n_req_if #(
   parameter int unsigned IN_WIDTH = 16
);
   logic                       valid;
   logic                       ready;
   logic signed [IN_WIDTH-1:0] x_in;
   logic signed [IN_WIDTH-1:0] y_in;
   logic signed [IN_WIDTH-1:0] z_in;
   logic signed [IN_WIDTH-1:0] w_in;

   modport source (output valid, output x_in, output y_in, output z_in, output w_in,
                   input ready);
   modport sink   (input valid, input x_in, input y_in, input z_in, input w_in,
                   output ready);
endinterface

interface v4n_rsp_if #(
   parameter int unsigned COMP_WIDTH = 16,
   parameter int unsigned LEN_WIDTH  = 17
);
   logic                         valid;
   logic                         ready;
   logic signed [COMP_WIDTH-1:0] x_out;
   logic signed [COMP_WIDTH-1:0] y_out;
   logic signed [COMP_WIDTH-1:0] z_out;
   logic signed [COMP_WIDTH-1:0] w_out;
   logic        [LEN_WIDTH-1:0]  length;
   logic                         zero_vector;

   modport source (output valid, output x_out, output y_out, output z_out, output w_out,
                   output length, output zero_vector, input ready);
   modport sink   (input valid, input x_out, input y_out, input z_out, input w_out,
                   input length, input zero_vector, output ready);
endinterface

`default_nettype wire

// File: sv/v4n_div_cell.sv
// One restoring-division step on all four lanes, registered.
`default_nettype none

module v4n_div_cell import v4n_pkg::*; #(
   parameter int unsigned SUM_W = 33,
   parameter int unsigned QUO_W = 29,
   parameter bit          FIRST = 1'b0
) (
   input  logic                            clock,
   input  logic                            en,
   input  logic [SUM_W-1:0]                prev_sum,
   input  logic [LANES-1:0][SUM_W:0]       prev_rem,
   input  logic [LANES-1:0][QUO_W-1:0]     prev_quo,
   output logic [SUM_W-1:0]                sum_ff,
   output logic [LANES-1:0][SUM_W:0]       rem_ff,
   output logic [LANES-1:0][QUO_W-1:0]     quo_ff
);

   logic [LANES-1:0][SUM_W:0]   rem_in;
   logic [LANES-1:0][QUO_W-1:0] quo_in;
   logic [SUM_W:0]              twice;
   logic                        ge;

   // The first step yields the integer bit, so the remainder is not doubled.
   always_comb begin
      twice = '0;
      ge    = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         twice     = FIRST ? prev_rem[i] : {prev_rem[i][SUM_W-1:0], 1'b0};
         ge        = (twice >= {1'b0, prev_sum});
         rem_in[i] = ge ? (twice - {1'b0, prev_sum}) : twice;
         quo_in[i] = {prev_quo[i][QUO_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= prev_sum;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/v4n_sqrt_cell.sv
// One digit-by-digit square root step on a single lane, registered.
`default_nettype none

module v4n_sqrt_cell #(
   parameter int unsigned ROOT_W = 15,
   parameter int unsigned N_W    = 30
) (
   input  logic                clock,
   input  logic                en,
   input  logic [ROOT_W+1:0]   prev_rem,
   input  logic [ROOT_W-1:0]   prev_root,
   input  logic [N_W-1:0]      prev_n,
   output logic [ROOT_W+1:0]   rem_ff,
   output logic [ROOT_W-1:0]   root_ff,
   output logic [N_W-1:0]      n_ff
);

   localparam int unsigned REM_W = ROOT_W + 2;

   logic [REM_W-1:0]  cur;
   logic [REM_W-1:0]  trial;
   logic              ge;
   logic [REM_W-1:0]  rem_in;
   logic [ROOT_W-1:0] root_in;
   logic [N_W-1:0]    n_in;

   // Bring down the next two bits of the radicand and try root*4+1.
   always_comb begin
      cur     = {prev_rem[REM_W-3:0], prev_n[N_W-1 -: 2]};
      trial   = {prev_root, 2'b01};
      ge      = (cur >= trial);
      rem_in  = ge ? (cur - trial) : cur;
      root_in = {prev_root[ROOT_W-2:0], ge};
      n_in    = {prev_n[N_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         n_ff    <= n_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/vec4_normalize.sv
// Top level: pipelined four-component vector length and normalisation.
//
//   channel   direction   beat contents
//   req_bus   in          x_in, y_in, z_in, w_in (signed, IN_WIDTH bits)
//   rsp_bus   out         x_out..w_out (signed Q1.OUT_FRAC_BITS), length, zero_vector
//
// One beat is taken per cycle while the chain has room. Each beat passes through
// squaring, summing, one restoring-division cell per quotient bit, one square-root
// cell per root bit, and the output register. Reset clears only the valid bits of
// the chain. Each cell moves on when its successor has room, so bubbles close up and
// beats keep entering while the output is stalled.
`default_nettype none

module vec4_normalize import v4n_pkg::*; #(
   parameter int unsigned IN_WIDTH      = 16,
   parameter int unsigned OUT_FRAC_BITS = 14
) (
   input  logic        clock,
   input  logic        reset,
   v4n_req_if.sink     req_bus,
   v4n_rsp_if.source   rsp_bus
);

   localparam int unsigned SQ_W     = 2 * IN_WIDTH;
   localparam int unsigned SUM_W    = SQ_W + 1;
   localparam int unsigned DRW      = SUM_W + 1;
   localparam int unsigned QUO_W    = 2 * OUT_FRAC_BITS + 1;
   localparam int unsigned DIVS     = QUO_W;
   localparam int unsigned CRT_W    = OUT_FRAC_BITS + 1;
   localparam int unsigned CN_W     = 2 * OUT_FRAC_BITS + 2;
   localparam int unsigned CREM_W   = CRT_W + 2;
   localparam int unsigned COMP_END = DIVS + CRT_W;
   localparam int unsigned LRT_W    = IN_WIDTH + 1;
   localparam int unsigned LN_W     = 2 * IN_WIDTH + 2;
   localparam int unsigned LREM_W   = LRT_W + 2;
   localparam int unsigned NST      = max_u(COMP_END, LRT_W);
   localparam int unsigned COMP_W   = OUT_FRAC_BITS + 2;

   // Front stages
   logic [IN_WIDTH-1:0] raw     [LANES];
   logic [IN_WIDTH-1:0] mag     [LANES];
   logic [SQ_W-1:0]     sq_in   [LANES];
   logic [SQ_W-1:0]     sq_ff   [LANES];
   logic [LANES-1:0]    negp_ff;
   logic                vldp_ff;
   logic                advp;
   logic [SUM_W-1:0]    sum_in;

   // Chain registers, indexed by stage
   logic                          vld_ff  [0:NST];
   logic                          adv     [0:NST+1];
   logic [LANES-1:0]              negs_ff [0:NST];
   logic                          zer_ff  [0:NST];
   logic [SUM_W-1:0]              sum_ff  [0:DIVS];
   logic [LANES-1:0][DRW-1:0]     drem_ff [0:DIVS];
   logic [LANES-1:0][QUO_W-1:0]   quo_ff  [0:DIVS];
   logic [CREM_W-1:0]             crem_ff [DIVS+1:COMP_END][LANES];
   logic [CN_W-1:0]               cn_ff   [DIVS+1:COMP_END][LANES];
   logic [CRT_W-1:0]              croot_ff[DIVS+1:NST][LANES];
   logic [LREM_W-1:0]             lrem_ff [1:LRT_W];
   logic [LN_W-1:0]               ln_ff   [1:LRT_W];
   logic [LRT_W-1:0]              lroot_ff[1:NST];

   // Output register
   logic                out_vld_ff;
   logic [COMP_W-1:0]   comp_in  [LANES];
   logic [COMP_W-1:0]   comp_ff  [LANES];
   logic [LRT_W-1:0]    len_ff;
   logic                zero_ff;

   assign raw[0] = req_bus.x_in;
   assign raw[1] = req_bus.y_in;
   assign raw[2] = req_bus.z_in;
   assign raw[3] = req_bus.w_in;

   // Handshake: a stage advances when it is empty or its successor advances.
   assign adv[NST+1] = !out_vld_ff || rsp_bus.ready;
   for (genvar k = 0; k <= NST; k++) begin : g_adv
      assign adv[k] = !vld_ff[k] || adv[k+1];
   end
   assign advp          = !vldp_ff || adv[0];
   assign req_bus.ready = advp;

   // Magnitudes and squares; the most negative value keeps its full magnitude.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         mag[i]   = raw[i][IN_WIDTH-1] ? (~raw[i] + 1'b1) : raw[i];
         sq_in[i] = {{IN_WIDTH{1'b0}}, mag[i]} * {{IN_WIDTH{1'b0}}, mag[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vldp_ff <= 1'b0;
      end else if (advp) begin
         vldp_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advp) begin
         for (int i = 0; i < LANES; i++) begin
            sq_ff[i]   <= sq_in[i];
            negp_ff[i] <= raw[i][IN_WIDTH-1];
         end
      end
   end

   // Stage 0: sum of squares, division set-up.
   assign sum_in = {1'b0, sq_ff[0]} + {1'b0, sq_ff[1]} + {1'b0, sq_ff[2]} + {1'b0, sq_ff[3]};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv[0]) begin
         vld_ff[0] <= vldp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         sum_ff[0]  <= sum_in;
         negs_ff[0] <= negp_ff;
         zer_ff[0]  <= (sum_in == '0);
         for (int i = 0; i < LANES; i++) begin
            drem_ff[0][i] <= {2'b00, sq_ff[i]};
            quo_ff[0][i]  <= '0;
         end
      end
   end

   for (genvar k = 1; k <= NST; k++) begin : g_stage

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k]) begin
            negs_ff[k] <= negs_ff[k-1];
            zer_ff[k]  <= zer_ff[k-1];
         end
      end

      // Component lanes: quotient of square over sum, then its square root.
      if (k <= DIVS) begin : g_div
         v4n_div_cell #(
            .SUM_W (SUM_W),
            .QUO_W (QUO_W),
            .FIRST (k == 1)
         ) u_div (
            .clock    (clock),
            .en       (adv[k]),
            .prev_sum (sum_ff[k-1]),
            .prev_rem (drem_ff[k-1]),
            .prev_quo (quo_ff[k-1]),
            .sum_ff   (sum_ff[k]),
            .rem_ff   (drem_ff[k]),
            .quo_ff   (quo_ff[k])
         );
      end else if (k <= COMP_END) begin : g_csq
         for (genvar i = 0; i < LANES; i++) begin : g_lane
            logic [CREM_W-1:0] p_rem;
            logic [CRT_W-1:0]  p_root;
            logic [CN_W-1:0]   p_n;

            if (k == DIVS + 1) begin : g_start
               assign p_rem  = '0;
               assign p_root = '0;
               assign p_n    = {1'b0, quo_ff[k-1][i]};
            end else begin : g_next
               assign p_rem  = crem_ff[k-1][i];
               assign p_root = croot_ff[k-1][i];
               assign p_n    = cn_ff[k-1][i];
            end

            v4n_sqrt_cell #(
               .ROOT_W (CRT_W),
               .N_W    (CN_W)
            ) u_sqrt (
               .clock     (clock),
               .en        (adv[k]),
               .prev_rem  (p_rem),
               .prev_root (p_root),
               .prev_n    (p_n),
               .rem_ff    (crem_ff[k][i]),
               .root_ff   (croot_ff[k][i]),
               .n_ff      (cn_ff[k][i])
            );
         end
      end else begin : g_chold
         always_ff @(posedge clock) begin
            if (adv[k]) begin
               for (int i = 0; i < LANES; i++) begin
                  croot_ff[k][i] <= croot_ff[k-1][i];
               end
            end
         end
      end

      // Length lane: square root of the sum, alongside the division.
      if (k <= LRT_W) begin : g_lsq
         logic [LREM_W-1:0] p_rem;
         logic [LRT_W-1:0]  p_root;
         logic [LN_W-1:0]   p_n;

         if (k == 1) begin : g_start
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_n    = {1'b0, sum_ff[0]};
         end else begin : g_next
            assign p_rem  = lrem_ff[k-1];
            assign p_root = lroot_ff[k-1];
            assign p_n    = ln_ff[k-1];
         end

         v4n_sqrt_cell #(
            .ROOT_W (LRT_W),
            .N_W    (LN_W)
         ) u_sqrt (
            .clock     (clock),
            .en        (adv[k]),
            .prev_rem  (p_rem),
            .prev_root (p_root),
            .prev_n    (p_n),
            .rem_ff    (lrem_ff[k]),
            .root_ff   (lroot_ff[k]),
            .n_ff      (ln_ff[k])
         );
      end else begin : g_lhold
         always_ff @(posedge clock) begin
            if (adv[k]) begin
               lroot_ff[k] <= lroot_ff[k-1];
            end
         end
      end
   end

   // Restore signs; a zero vector forces zero components.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (zer_ff[NST]) begin
            comp_in[i] = '0;
         end else if (negs_ff[NST][i]) begin
            comp_in[i] = ~{1'b0, croot_ff[NST][i]} + 1'b1;
         end else begin
            comp_in[i] = {1'b0, croot_ff[NST][i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv[NST+1]) begin
         out_vld_ff <= vld_ff[NST];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[NST+1]) begin
         comp_ff <= comp_in;
         len_ff  <= lroot_ff[NST];
         zero_ff <= zer_ff[NST];
      end
   end

   assign rsp_bus.valid       = out_vld_ff;
   assign rsp_bus.x_out       = comp_ff[0];
   assign rsp_bus.y_out       = comp_ff[1];
   assign rsp_bus.z_out       = comp_ff[2];
   assign rsp_bus.w_out       = comp_ff[3];
   assign rsp_bus.length      = len_ff;
   assign rsp_bus.zero_vector = zero_ff;

endmodule

`default_nettype wire

// File: sv/v4n_checker.sv
// Port-level assertions for the vector normaliser, bound to the top level.
`default_nettype none

module v4n_checker #(
   parameter int unsigned COMP_WIDTH = 16,
   parameter int unsigned LEN_WIDTH  = 17
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [COMP_WIDTH-1:0] x_out,
   input logic signed [COMP_WIDTH-1:0] y_out,
   input logic signed [COMP_WIDTH-1:0] z_out,
   input logic signed [COMP_WIDTH-1:0] w_out,
   input logic        [LEN_WIDTH-1:0]  length,
   input logic                         zero_vector
);

   localparam logic signed [COMP_WIDTH-1:0] UNIT = 1 <<< (COMP_WIDTH - 2);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat withdrawn before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable({x_out, y_out, z_out, w_out, length, zero_vector}))
      else $error("stalled response beat changed");

   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && zero_vector |->
         length == '0 && x_out == '0 && y_out == '0 && z_out == '0 && w_out == '0)
      else $error("zero vector with nonzero result");

   a_nonzero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !zero_vector |-> length != '0)
      else $error("nonzero vector with zero length");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         x_out <= UNIT && x_out >= -UNIT && y_out <= UNIT && y_out >= -UNIT &&
         z_out <= UNIT && z_out >= -UNIT && w_out <= UNIT && w_out >= -UNIT)
      else $error("normalised component exceeds one");

endmodule

bind vec4_normalize v4n_checker #(
   .COMP_WIDTH (OUT_FRAC_BITS + 2),
   .LEN_WIDTH  (IN_WIDTH + 1)
) u_v4n_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .x_out       (rsp_bus.x_out),
   .y_out       (rsp_bus.y_out),
   .z_out       (rsp_bus.z_out),
   .w_out       (rsp_bus.w_out),
   .length      (rsp_bus.length),
   .zero_vector (rsp_bus.zero_vector)
);

`default_nettype wire

// File: tb/v4n_tb_if.sv
// Result record type shared by the testbench; the channel interfaces come from the RTL.
`timescale 1ns / 1ps

package v4n_tb_pkg;

   typedef struct packed {
      logic signed [15:0] x_out;
      logic signed [15:0] y_out;
      logic signed [15:0] z_out;
      logic signed [15:0] w_out;
      logic [16:0]        length;
      logic               zero_vector;
   } norm_beat_type;

endpackage

// File: tb/vec4_normalize_test.sv
// Self-checking testbench for the four-component vector normaliser.
`timescale 1ns / 1ps

module vec4_normalize_test;
   import v4n_tb_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned N_RANDOM       = 1800;
   localparam int unsigned DRAIN_CYCLES   = 60;

   typedef struct {
      logic [15:0]   x, y, z, w;
      logic          known;
      norm_beat_type res;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   v4n_req_if #(.IN_WIDTH(16)) req_bus ();
   v4n_rsp_if #(.COMP_WIDTH(16), .LEN_WIDTH(17)) rsp_bus ();

   vec4_normalize #(.IN_WIDTH(16), .OUT_FRAC_BITS(14)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   norm_beat_type pending_norms[$];
   int unsigned   mismatches = 0;
   int unsigned   idle_cycles = 0;
   bit            quiet_phase = 1'b0;
   bit            timed_out = 1'b0;

   function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] root, bitv, rem;
      root = 0;
      rem  = n;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem  = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic norm_beat_type normalise(input logic [15:0] x, y, z, w);
      logic [15:0]   comp[4];
      logic [63:0]   mag[4];
      logic [63:0]   sum, q, len;
      norm_beat_type r;
      comp[0] = x; comp[1] = y; comp[2] = z; comp[3] = w;
      sum = 0;
      for (int i = 0; i < 4; i++) begin
         mag[i] = comp[i][15] ? 64'(17'h10000 - 17'(comp[i])) : 64'(comp[i]);
         sum += mag[i] * mag[i];
      end
      r = '0;
      if (sum == 0) begin
         r.zero_vector = 1'b1;
         return r;
      end
      for (int i = 0; i < 4; i++) begin
         q = int_sqrt(((mag[i] * mag[i]) << 28) / sum);
         if (comp[i][15]) q = -q;
         case (i)
            0: r.x_out = q[15:0];
            1: r.y_out = q[15:0];
            2: r.z_out = q[15:0];
            default: r.w_out = q[15:0];
         endcase
      end
      len = int_sqrt(sum);
      r.length = len[16:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [16:0] exp_v, act_v);
      mismatches++;
      if (mismatches <= 10)
         $display("Mismatch on %s: expected %0h, got %0h", what, exp_v, act_v);
   endtask

   // Response side: sample at the rising edge, drive ready at the falling edge.
   int unsigned rsp_stall = 0;
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         norm_beat_type exp_b;
         if (pending_norms.size() == 0) begin
            report_mismatch("unexpected beat", 17'd0, 17'd1);
         end else begin
            exp_b = pending_norms.pop_front();
            if (exp_b.x_out !== rsp_bus.x_out)
               report_mismatch("x_out", 17'(exp_b.x_out), 17'(rsp_bus.x_out));
            if (exp_b.y_out !== rsp_bus.y_out)
               report_mismatch("y_out", 17'(exp_b.y_out), 17'(rsp_bus.y_out));
            if (exp_b.z_out !== rsp_bus.z_out)
               report_mismatch("z_out", 17'(exp_b.z_out), 17'(rsp_bus.z_out));
            if (exp_b.w_out !== rsp_bus.w_out)
               report_mismatch("w_out", 17'(exp_b.w_out), 17'(rsp_bus.w_out));
            if (exp_b.length !== rsp_bus.length)
               report_mismatch("length", exp_b.length, rsp_bus.length);
            if (exp_b.zero_vector !== rsp_bus.zero_vector)
               report_mismatch("zero_vector", 17'(exp_b.zero_vector),
                               17'(rsp_bus.zero_vector));
         end
      end
   end

   initial rsp_bus.ready = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = rsp_stall - 1;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = $urandom_range(0, 16);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Watchdog: cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("Watchdog expired");
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Drives one request beat, idling at random first; returns once it is accepted.
   task automatic send_vector(input logic [15:0] x, y, z, w, input bit known,
                              input norm_beat_type given);
      int unsigned   gap;
      norm_beat_type exp_b;
      if (!quiet_phase && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 17);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.x_in  <= x;
      req_bus.y_in  <= y;
      req_bus.z_in  <= z;
      req_bus.w_in  <= w;
      exp_b = known ? given : normalise(x, y, z, w);
      // Queue the expectation before the edge at which the beat can move.
      pending_norms.push_back(exp_b);
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   function automatic logic [15:0] random_component();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'(($urandom_range(0, 15)) - 8);
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   stim_row_type directed[$];

   function automatic stim_row_type row(input logic [15:0] x, y, z, w,
                                        input bit known = 1'b0,
                                        input norm_beat_type res = '0);
      stim_row_type r;
      r.x = x; r.y = y; r.z = z; r.w = w; r.known = known; r.res = res;
      return r;
   endfunction

   initial begin
      norm_beat_type zero_res, unit_x, neg_full;
      logic [15:0]   v[4];
      zero_res = '0; zero_res.zero_vector = 1'b1;
      unit_x   = '0; unit_x.x_out = 16'sd16384; unit_x.length = 17'd2048;
      neg_full = '0;
      neg_full.x_out = -16'sd8192; neg_full.y_out = -16'sd8192;
      neg_full.z_out = -16'sd8192; neg_full.w_out = -16'sd8192;
      neg_full.length = 17'd65536;

      directed.push_back(row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, zero_res));
      directed.push_back(row(16'h0800, 16'h0000, 16'h0000, 16'h0000, 1'b1, unit_x));
      directed.push_back(row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, neg_full));
      directed.push_back(row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      directed.push_back(row(16'h8000, 16'h0000, 16'h0000, 16'h0000));
      directed.push_back(row(16'h0000, 16'h8000, 16'h0000, 16'h0000));
      directed.push_back(row(16'h0000, 16'h0000, 16'h7FFF, 16'h0000));
      directed.push_back(row(16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
      directed.push_back(row(16'h0001, 16'h0000, 16'h0000, 16'h0000));
      directed.push_back(row(16'h0001, 16'h0001, 16'h0001, 16'h0001));
      directed.push_back(row(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
      directed.push_back(row(16'h0001, 16'h7FFF, 16'hFFFF, 16'h8000));
      directed.push_back(row(16'h5555, 16'hAAAA, 16'h3333, 16'hCCCC));
      directed.push_back(row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));

      req_bus.valid = 1'b0;
      req_bus.x_in  = '0;
      req_bus.y_in  = '0;
      req_bus.z_in  = '0;
      req_bus.w_in  = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i])
         send_vector(directed[i].x, directed[i].y, directed[i].z, directed[i].w,
                     directed[i].known, directed[i].res);

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM - 300) quiet_phase = 1'b1;
         foreach (v[k]) v[k] = random_component();
         send_vector(v[0], v[1], v[2], v[3], 1'b0, '0);
      end
      req_bus.valid <= 1'b0;

      while (pending_norms.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatches == 0 && pending_norms.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: vec4_normalize.f
sv/v4n_pkg.sv
sv/v4n_if.sv
sv/v4n_div_cell.sv
sv/v4n_sqrt_cell.sv
sv/vec4_normalize.sv
sv/v4n_checker.sv
tb/v4n_tb_if.sv
tb/vec4_normalize_test.sv
